### hw/rtl/scl_pkg.sv
package scl_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [23:0] SETTLE_RESET = 24'd1000;

  // host command codes as they arrive on the input channel
  typedef enum logic [2:0] {
    CMD_TICK        = 3'd0,
    CMD_START       = 3'd1,
    CMD_BYTE        = 3'd2,
    CMD_FINISH      = 3'd3,
    CMD_READ_ID     = 3'd4,
    CMD_READ_STATUS = 3'd5,
    CMD_NONE        = 3'd6
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        is_host;
    logic [7:0]  data;
    logic        miso;
  } item_t;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'd0,
    ST_REFRESH  = 5'd1,
    ST_POLL1    = 5'd2,
    ST_POLL1_RD = 5'd3,
    ST_WAIT     = 5'd4,
    ST_ENABLE   = 5'd5,
    ST_ERASE    = 5'd6,
    ST_POLL2    = 5'd7,
    ST_POLL2_RD = 5'd8,
    ST_ADDR     = 5'd9,
    ST_STAT     = 5'd10,
    ST_STAT_RD  = 5'd11,
    ST_BURST    = 5'd12,
    ST_BYTE     = 5'd13,
    ST_FSTAT    = 5'd14,
    ST_FSTAT_RD = 5'd15,
    ST_DISABLE  = 5'd16,
    ST_ID       = 5'd17,
    ST_ID_RD    = 5'd18,
    ST_RS       = 5'd19,
    ST_RS_RD    = 5'd20
  } step_t;

  typedef enum logic [2:0] {
    SK_IDLE = 3'd0,
    SK_OP   = 3'd1,
    SK_RD   = 3'd2,
    SK_WAIT = 3'd3,
    SK_BYTE = 3'd4
  } step_kind_t;

  localparam logic [7:0] OP_REFRESH   = 8'h79;
  localparam logic [7:0] OP_READ_ID   = 8'hE0;
  localparam logic [7:0] OP_STATUS    = 8'h3C;
  localparam logic [7:0] OP_BUSY      = 8'hF0;
  localparam logic [7:0] OP_ENABLE    = 8'hC6;
  localparam logic [7:0] OP_ERASE     = 8'h0E;
  localparam logic [7:0] OP_ADDRESS   = 8'h46;
  localparam logic [7:0] OP_BURST     = 8'h7A;
  localparam logic [7:0] OP_DISABLE   = 8'h26;

  localparam logic [5:0] OP_LAST_BIT  = 6'd32;
  localparam logic [5:0] BYTE_BITS    = 6'd8;

  typedef struct packed {
    step_kind_t  kind;
    logic [7:0]  opcode;
    logic [5:0]  len;
    step_t       next;
  } step_desc_t;

  typedef struct packed {
    logic        cs_active;
    logic        mosi_bit;
    logic        clock_pulse;
    logic        engine_busy;
    logic        response_valid;
    logic [31:0] response_word;
    logic        command_rejected;
  } result_t;

  function automatic step_desc_t step_desc(step_t s);
    step_desc_t d;
    d = '{SK_IDLE, 8'h00, 6'd0, ST_IDLE};
    unique case (s)
      ST_IDLE:     d = '{SK_IDLE, 8'h00,       6'd0,  ST_IDLE};
      ST_REFRESH:  d = '{SK_OP,   OP_REFRESH,  6'd0,  ST_POLL1};
      ST_POLL1:    d = '{SK_OP,   OP_BUSY,     6'd0,  ST_POLL1_RD};
      ST_POLL1_RD: d = '{SK_RD,   8'h00,       6'd8,  ST_IDLE};
      ST_WAIT:     d = '{SK_WAIT, 8'h00,       6'd0,  ST_ENABLE};
      ST_ENABLE:   d = '{SK_OP,   OP_ENABLE,   6'd0,  ST_ERASE};
      ST_ERASE:    d = '{SK_OP,   OP_ERASE,    6'd0,  ST_POLL2};
      ST_POLL2:    d = '{SK_OP,   OP_BUSY,     6'd0,  ST_POLL2_RD};
      ST_POLL2_RD: d = '{SK_RD,   8'h00,       6'd8,  ST_ADDR};
      ST_ADDR:     d = '{SK_OP,   OP_ADDRESS,  6'd0,  ST_STAT};
      ST_STAT:     d = '{SK_OP,   OP_STATUS,   6'd0,  ST_STAT_RD};
      ST_STAT_RD:  d = '{SK_RD,   8'h00,       6'd32, ST_BURST};
      ST_BURST:    d = '{SK_OP,   OP_BURST,    6'd0,  ST_IDLE};
      ST_BYTE:     d = '{SK_BYTE, 8'h00,       6'd8,  ST_IDLE};
      ST_FSTAT:    d = '{SK_OP,   OP_STATUS,   6'd0,  ST_FSTAT_RD};
      ST_FSTAT_RD: d = '{SK_RD,   8'h00,       6'd32, ST_DISABLE};
      ST_DISABLE:  d = '{SK_OP,   OP_DISABLE,  6'd0,  ST_IDLE};
      ST_ID:       d = '{SK_OP,   OP_READ_ID,  6'd0,  ST_ID_RD};
      ST_ID_RD:    d = '{SK_RD,   8'h00,       6'd32, ST_IDLE};
      ST_RS:       d = '{SK_OP,   OP_STATUS,   6'd0,  ST_RS_RD};
      ST_RS_RD:    d = '{SK_RD,   8'h00,       6'd32, ST_IDLE};
      default:     d = '{SK_IDLE, 8'h00,       6'd0,  ST_IDLE};
    endcase
    return d;
  endfunction

endpackage

### hw/rtl/fpga_spi_config_loader.sv
// flow: a beat accepted into the queue waits there, then is retired into the engine's
//   result register, from which its result shows
// throughput: one beat per cycle while out_stall is low; each tick is one sequencer pass
// reset: synchronous active low, sequencer idle, chip select released, settle ticks 1000
module fpga_spi_config_loader #(
  parameter int unsigned QUEUE_DEPTH = scl_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: settle tick count
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_data_byte,
  input  logic        in_miso_bit,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_cs_active,
  output logic        out_mosi_bit,
  output logic        out_clock_pulse,
  output logic        out_engine_busy,
  output logic        out_response_valid,
  output logic [31:0] out_response_word,
  output logic        out_command_rejected
);

  logic [23:0]      settle_r;
  scl_pkg::item_t   front_item;
  scl_pkg::item_t   head_item;
  logic             q_not_empty;
  logic             q_full;
  logic             q_pop;
  scl_pkg::result_t res;

  // settle count; the user must write it only while the engine is quiet, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= scl_pkg::SETTLE_RESET;
    end else if (cfg_wr_en) begin
      settle_r <= cfg_wr_data;
    end
  end

  // front: sort each beat into tick, host command or nothing
  scl_front u_front (
    .command   (in_command),
    .data_byte (in_data_byte),
    .miso_bit  (in_miso_bit),
    .item      (front_item)
  );

  // short queue so the host side keeps flowing while a result waits
  assign in_stall = q_full;

  scl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !q_full),
    .push_item (front_item),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .full      (q_full),
    .head_item (head_item)
  );

  // back: spi sequencer, one beat per cycle into the result register while out_stall is low
  scl_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .settle_ticks (settle_r),
    .item_valid   (q_not_empty),
    .item         (head_item),
    .item_pop     (q_pop),
    .res_valid    (out_valid),
    .res_stall    (out_stall),
    .res          (res)
  );

  assign out_cs_active        = res.cs_active;
  assign out_mosi_bit         = res.mosi_bit;
  assign out_clock_pulse      = res.clock_pulse;
  assign out_engine_busy      = res.engine_busy;
  assign out_response_valid   = res.response_valid;
  assign out_response_word    = res.response_word;
  assign out_command_rejected = res.command_rejected;

endmodule

### hw/rtl/scl_front.sv
module scl_front (
  input  logic [2:0]          command,
  input  logic [7:0]          data_byte,
  input  logic                miso_bit,
  output scl_pkg::item_t      item
);

  scl_pkg::cmd_kind_t kind;

  // codes six and seven carry no meaning and are dropped later
  always_comb begin
    unique case (scl_pkg::cmd_kind_t'(command))
      scl_pkg::CMD_TICK,
      scl_pkg::CMD_START,
      scl_pkg::CMD_BYTE,
      scl_pkg::CMD_FINISH,
      scl_pkg::CMD_READ_ID,
      scl_pkg::CMD_READ_STATUS: kind = scl_pkg::cmd_kind_t'(command);
      default:                  kind = scl_pkg::CMD_NONE;
    endcase
  end

  assign item.kind    = kind;
  assign item.is_host = (kind != scl_pkg::CMD_TICK) && (kind != scl_pkg::CMD_NONE);
  assign item.data    = data_byte;
  assign item.miso    = miso_bit;

endmodule

### hw/rtl/scl_queue.sv
module scl_queue #(
  parameter int unsigned DEPTH = scl_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  scl_pkg::item_t  push_item,
  input  logic            pop,
  output logic            not_empty,
  output logic            full,
  output scl_pkg::item_t  head_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  scl_pkg::item_t   slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == FULL_CNT);
  assign head_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### hw/rtl/scl_back.sv
module scl_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [23:0]       settle_ticks,
  input  logic              item_valid,
  input  scl_pkg::item_t    item,
  output logic              item_pop,
  output logic              res_valid,
  input  logic              res_stall,
  output scl_pkg::result_t  res
);

  scl_pkg::step_t      step_r, step_nxt, target;
  logic [5:0]          bit_cnt_r, bit_cnt_nxt;
  logic [7:0]          shift_out_r, shift_out_nxt;
  logic [31:0]         shift_in_r, shift_in_nxt;
  logic [23:0]         wait_cnt_r, wait_cnt_nxt;
  logic                burst_open_r, burst_open_nxt;
  logic [31:0]         saved_r, saved_nxt;
  logic                enter;

  logic                out_valid_r;
  scl_pkg::result_t    out_r, out_nxt;

  scl_pkg::step_desc_t desc;
  scl_pkg::step_desc_t tgt_desc;
  logic                is_tick, busy, is_poll;
  logic [5:0]          cnt_inc;
  logic [4:0]          rd_pos;
  logic [31:0]         shift_in_upd;
  logic                op_done, rd_done;
  logic [23:0]         wait_dec;

  // take the next item whenever the result register is free or being drained
  assign item_pop = item_valid && (!out_valid_r || !res_stall);

  assign desc     = scl_pkg::step_desc(step_r);
  assign is_tick  = (item.kind == scl_pkg::CMD_TICK);
  assign busy     = (step_r != scl_pkg::ST_IDLE);
  assign is_poll  = (step_r == scl_pkg::ST_POLL1_RD) || (step_r == scl_pkg::ST_POLL2_RD);
  assign cnt_inc  = bit_cnt_r + 6'd1;
  // read bits land msb first within each byte, bytes little-endian
  assign rd_pos   = {bit_cnt_r[4:3], ~bit_cnt_r[2:0]};
  assign shift_in_upd = shift_in_r | ({31'd0, item.miso} << rd_pos);
  assign op_done  = (cnt_inc > scl_pkg::OP_LAST_BIT);
  assign rd_done  = (cnt_inc >= desc.len);
  assign wait_dec = (wait_cnt_r != '0) ? wait_cnt_r - 24'd1 : wait_cnt_r;

  // next state
  always_comb begin
    step_nxt       = step_r;
    bit_cnt_nxt    = bit_cnt_r;
    shift_out_nxt  = shift_out_r;
    shift_in_nxt   = shift_in_r;
    wait_cnt_nxt   = wait_cnt_r;
    burst_open_nxt = burst_open_r;
    saved_nxt      = saved_r;
    enter          = 1'b0;
    target         = step_r;
    if (item_pop) begin
      if (!is_tick) begin
        if (!(busy && item.is_host)) begin
          unique case (item.kind)
            scl_pkg::CMD_START: begin
              burst_open_nxt = 1'b0;
              enter = 1'b1; target = scl_pkg::ST_REFRESH;
            end
            scl_pkg::CMD_BYTE: begin
              if (burst_open_r) begin
                shift_out_nxt = item.data;
                enter = 1'b1; target = scl_pkg::ST_BYTE;
              end
            end
            scl_pkg::CMD_FINISH: begin
              burst_open_nxt = 1'b0;
              enter = 1'b1; target = scl_pkg::ST_FSTAT;
            end
            scl_pkg::CMD_READ_ID: begin
              burst_open_nxt = 1'b0;
              enter = 1'b1; target = scl_pkg::ST_ID;
            end
            scl_pkg::CMD_READ_STATUS: begin
              burst_open_nxt = 1'b0;
              enter = 1'b1; target = scl_pkg::ST_RS;
            end
            default: begin
            end
          endcase
        end
      end else begin
        unique case (desc.kind)
          scl_pkg::SK_WAIT: begin
            wait_cnt_nxt = wait_dec;
            if (wait_dec == '0) begin
              enter = 1'b1; target = scl_pkg::ST_ENABLE;
            end
          end
          scl_pkg::SK_OP: begin
            if (bit_cnt_r == '0) begin
              shift_out_nxt = desc.opcode;
              bit_cnt_nxt   = 6'd1;
            end else begin
              shift_out_nxt = {shift_out_r[6:0], 1'b0};
              bit_cnt_nxt   = cnt_inc;
              if (op_done) begin
                if (step_r == scl_pkg::ST_BURST) begin
                  burst_open_nxt = 1'b1;
                end
                enter = 1'b1; target = desc.next;
              end
            end
          end
          scl_pkg::SK_RD: begin
            shift_in_nxt = shift_in_upd;
            bit_cnt_nxt  = cnt_inc;
            if (rd_done) begin
              enter = 1'b1;
              if (is_poll) begin
                if (shift_in_upd[7:0] != 8'd0) begin
                  target = (step_r == scl_pkg::ST_POLL1_RD) ? scl_pkg::ST_POLL1
                                                            : scl_pkg::ST_POLL2;
                end else if (step_r == scl_pkg::ST_POLL1_RD) begin
                  if (settle_ticks == '0) begin
                    target = scl_pkg::ST_ENABLE;
                  end else begin
                    wait_cnt_nxt = settle_ticks;
                    target       = scl_pkg::ST_WAIT;
                  end
                end else begin
                  target = desc.next;
                end
              end else begin
                if (step_r == scl_pkg::ST_FSTAT_RD) begin
                  saved_nxt = shift_in_upd;
                end
                target = desc.next;
              end
            end
          end
          scl_pkg::SK_BYTE: begin
            shift_out_nxt = {shift_out_r[6:0], 1'b0};
            bit_cnt_nxt   = cnt_inc;
            if (cnt_inc >= scl_pkg::BYTE_BITS) begin
              enter = 1'b1; target = scl_pkg::ST_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
    end
    tgt_desc = scl_pkg::step_desc(target);
    if (enter) begin
      step_nxt    = target;
      bit_cnt_nxt = '0;
      if (tgt_desc.kind == scl_pkg::SK_RD) begin
        shift_in_nxt = '0;
      end
    end
  end

  // outputs of the item being retired
  always_comb begin
    out_nxt = '0;
    if (is_tick) begin
      unique case (desc.kind)
        scl_pkg::SK_OP: begin
          if (bit_cnt_r != '0) begin
            out_nxt.cs_active   = 1'b1;
            out_nxt.clock_pulse = 1'b1;
            out_nxt.mosi_bit    = shift_out_r[7];
            if (op_done && step_r == scl_pkg::ST_DISABLE) begin
              out_nxt.response_valid = 1'b1;
              out_nxt.response_word  = saved_r;
            end
          end
        end
        scl_pkg::SK_RD: begin
          out_nxt.cs_active   = 1'b1;
          out_nxt.clock_pulse = 1'b1;
          if (rd_done && !is_poll && step_r != scl_pkg::ST_FSTAT_RD) begin
            out_nxt.response_valid = 1'b1;
            out_nxt.response_word  = shift_in_upd;
          end
        end
        scl_pkg::SK_BYTE: begin
          out_nxt.cs_active   = 1'b1;
          out_nxt.clock_pulse = 1'b1;
          out_nxt.mosi_bit    = shift_out_r[7];
        end
        scl_pkg::SK_IDLE: begin
          out_nxt.cs_active = burst_open_r;
        end
        default: begin
        end
      endcase
    end
    out_nxt.command_rejected = !is_tick && item.is_host && busy;
    out_nxt.engine_busy      = (step_nxt != scl_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= scl_pkg::ST_IDLE;
      bit_cnt_r    <= '0;
      shift_out_r  <= '0;
      shift_in_r   <= '0;
      wait_cnt_r   <= '0;
      burst_open_r <= 1'b0;
      saved_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      step_r       <= step_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      shift_out_r  <= shift_out_nxt;
      shift_in_r   <= shift_in_nxt;
      wait_cnt_r   <= wait_cnt_nxt;
      burst_open_r <= burst_open_nxt;
      saved_r      <= saved_nxt;
      out_valid_r  <= item_pop || (out_valid_r && res_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      out_r <= out_nxt;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

  a_burst_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    burst_open_r |-> (step_r == scl_pkg::ST_IDLE || step_r == scl_pkg::ST_BYTE))
    else $error("burst open outside idle or byte step");

  a_wait_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == scl_pkg::ST_WAIT) |-> (wait_cnt_r != '0))
    else $error("wait step with empty counter");

  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.command_rejected) |-> out_r.engine_busy)
    else $error("rejected command reported with engine idle");

  a_clock_has_cs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.clock_pulse) |-> out_r.cs_active)
    else $error("spi clock without chip select");

  a_word_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.response_valid) |-> (out_r.response_word == '0))
    else $error("response word not cleared without response");

endmodule

### test/fpga_spi_config_loader_check.sv
`timescale 1ns / 1ps

module fpga_spi_config_loader_check
  import scl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_data_byte,
  input  logic        in_miso_bit,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_cs_active,
  input  logic        out_mosi_bit,
  input  logic        out_clock_pulse,
  input  logic        out_engine_busy,
  input  logic        out_response_valid,
  input  logic [31:0] out_response_word,
  input  logic        out_command_rejected,
  output int          mismatches,
  output int          beats_due
);

  localparam logic [5:0] WORD_BITS = 6'd32;

  // own copy of the sequencer
  logic [23:0] settle_now;
  step_t       step_now;
  logic [5:0]  bit_idx;
  logic [7:0]  tx_shift;
  logic [31:0] rx_shift;
  logic [23:0] settle_left;
  logic        burst_held;
  logic [31:0] status_kept;

  result_t     bus_beats_due[$];

  initial mismatches = 0;
  initial beats_due = 0;

  function automatic string beat_text(input result_t r);
    return $sformatf("cs %b mosi %b sck %b busy %b resp %b word %h rej %b",
                     r.cs_active, r.mosi_bit, r.clock_pulse, r.engine_busy,
                     r.response_valid, r.response_word, r.command_rejected);
  endfunction

  function automatic bit is_read_step(input step_t s);
    return s inside {ST_POLL1_RD, ST_POLL2_RD, ST_STAT_RD, ST_FSTAT_RD, ST_ID_RD, ST_RS_RD};
  endfunction

  function automatic logic [7:0] opcode_for(input step_t s);
    case (s)
      ST_REFRESH:                return OP_REFRESH;
      ST_POLL1, ST_POLL2:        return OP_BUSY;
      ST_ENABLE:                 return OP_ENABLE;
      ST_ERASE:                  return OP_ERASE;
      ST_ADDR:                   return OP_ADDRESS;
      ST_STAT, ST_FSTAT, ST_RS:  return OP_STATUS;
      ST_BURST:                  return OP_BURST;
      ST_DISABLE:                return OP_DISABLE;
      ST_ID:                     return OP_READ_ID;
      default:                   return 8'h00;
    endcase
  endfunction

  function automatic step_t after_opcode(input step_t s);
    case (s)
      ST_REFRESH: return ST_POLL1;
      ST_POLL1:   return ST_POLL1_RD;
      ST_ENABLE:  return ST_ERASE;
      ST_ERASE:   return ST_POLL2;
      ST_POLL2:   return ST_POLL2_RD;
      ST_ADDR:    return ST_STAT;
      ST_STAT:    return ST_STAT_RD;
      ST_FSTAT:   return ST_FSTAT_RD;
      ST_ID:      return ST_ID_RD;
      ST_RS:      return ST_RS_RD;
      default:    return ST_IDLE;
    endcase
  endfunction

  task automatic enter_step(input step_t s);
    step_now = s;
    bit_idx  = '0;
    if (is_read_step(s)) rx_shift = '0;
  endtask

  task automatic advance_sequencer(input logic [2:0] cmd, input logic [7:0] data,
                                   input logic miso, output result_t r);
    logic [4:0] k;
    logic [5:0] read_len;
    r = '0;
    if (cmd != CMD_TICK) begin
      if (cmd <= CMD_READ_STATUS && step_now != ST_IDLE) begin
        r.command_rejected = 1'b1;
      end else begin
        case (cmd)
          CMD_START: begin
            burst_held = 1'b0;
            enter_step(ST_REFRESH);
          end
          CMD_BYTE: begin
            if (burst_held) begin
              tx_shift = data;
              enter_step(ST_BYTE);
            end
          end
          CMD_FINISH: begin
            burst_held = 1'b0;
            enter_step(ST_FSTAT);
          end
          CMD_READ_ID: begin
            burst_held = 1'b0;
            enter_step(ST_ID);
          end
          CMD_READ_STATUS: begin
            burst_held = 1'b0;
            enter_step(ST_RS);
          end
          default: ;
        endcase
      end
    end else begin
      case (step_now)
        ST_IDLE: r.cs_active = burst_held;
        ST_WAIT: begin
          if (settle_left != '0) settle_left = settle_left - 24'd1;
          if (settle_left == '0) enter_step(ST_ENABLE);
        end
        ST_BYTE: begin
          r.cs_active   = 1'b1;
          r.clock_pulse = 1'b1;
          r.mosi_bit    = tx_shift[7];
          tx_shift      = tx_shift << 1;
          bit_idx       = bit_idx + 6'd1;
          if (bit_idx >= BYTE_BITS) enter_step(ST_IDLE);
        end
        default: begin
          if (is_read_step(step_now)) begin
            // msb first within a byte, bytes little-endian in the word
            k = bit_idx[4:0];
            r.cs_active   = 1'b1;
            r.clock_pulse = 1'b1;
            if (miso) rx_shift[{k[4:3], ~k[2:0]}] = 1'b1;
            bit_idx  = bit_idx + 6'd1;
            read_len = (step_now == ST_POLL1_RD || step_now == ST_POLL2_RD) ?
                       BYTE_BITS : WORD_BITS;
            if (bit_idx >= read_len) begin
              case (step_now)
                ST_POLL1_RD, ST_POLL2_RD: begin
                  if (rx_shift[7:0] != 8'h00)
                    enter_step(step_now == ST_POLL1_RD ? ST_POLL1 : ST_POLL2);
                  else if (step_now == ST_POLL2_RD)
                    enter_step(ST_ADDR);
                  else if (settle_now == '0)
                    enter_step(ST_ENABLE);
                  else begin
                    settle_left = settle_now;
                    enter_step(ST_WAIT);
                  end
                end
                ST_FSTAT_RD: begin
                  status_kept = rx_shift;
                  enter_step(ST_DISABLE);
                end
                ST_STAT_RD: begin
                  r.response_valid = 1'b1;
                  r.response_word  = rx_shift;
                  enter_step(ST_BURST);
                end
                default: begin
                  r.response_valid = 1'b1;
                  r.response_word  = rx_shift;
                  enter_step(ST_IDLE);
                end
              endcase
            end
          end else if (bit_idx == '0) begin
            // gap tick, chip select released
            tx_shift = opcode_for(step_now);
            bit_idx  = 6'd1;
          end else begin
            r.cs_active   = 1'b1;
            r.clock_pulse = 1'b1;
            r.mosi_bit    = tx_shift[7];
            tx_shift      = tx_shift << 1;
            bit_idx       = bit_idx + 6'd1;
            if (bit_idx > OP_LAST_BIT) begin
              if (step_now == ST_BURST) burst_held = 1'b1;
              if (step_now == ST_DISABLE) begin
                r.response_valid = 1'b1;
                r.response_word  = status_kept;
              end
              enter_step(after_opcode(step_now));
            end
          end
        end
      endcase
    end
    r.engine_busy = (step_now != ST_IDLE);
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t seen;
    if (!rst_n) begin
      settle_now  = SETTLE_RESET;
      step_now    = ST_IDLE;
      bit_idx     = '0;
      tx_shift    = '0;
      rx_shift    = '0;
      settle_left = '0;
      burst_held  = 1'b0;
      status_kept = '0;
      bus_beats_due.delete();
    end else begin
      if (cfg_wr_en) settle_now = cfg_wr_data;
      if (out_valid && !out_stall) begin
        seen = '{out_cs_active, out_mosi_bit, out_clock_pulse, out_engine_busy,
                 out_response_valid, out_response_word, out_command_rejected};
        if (bus_beats_due.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %s",
                   $time, beat_text(seen));
          mismatches++;
        end else begin
          want = bus_beats_due.pop_front();
          if (seen !== want) begin
            $display("%0t: mismatch, expected %s, actual %s",
                     $time, beat_text(want), beat_text(seen));
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        advance_sequencer(in_command, in_data_byte, in_miso_bit, want);
        bus_beats_due.push_back(want);
      end
    end
    beats_due = bus_beats_due.size();
  end

endmodule

### test/tb_fpga_spi_config_loader.sv
`timescale 1ns / 1ps

module tb_fpga_spi_config_loader;
  import scl_pkg::*;

  // second unused command code, beside CMD_NONE
  localparam logic [2:0] CMD_SPARE   = 3'd7;
  // one gap tick with chip select released, then opcode and 24 zero bits
  localparam int         OP_TICKS    = 33;
  localparam int         WORD_TICKS  = 32;
  localparam int         BYTE_TICKS  = 8;
  // random beats after the configuration pass, counted from its end
  localparam int         PHASE_BEATS = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [23:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_command = CMD_TICK;
  logic [7:0]  in_data_byte = '0;
  logic        in_miso_bit = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_cs_active;
  logic        out_mosi_bit;
  logic        out_clock_pulse;
  logic        out_engine_busy;
  logic        out_response_valid;
  logic [31:0] out_response_word;
  logic        out_command_rejected;

  int          mismatches;
  int          beats_due;

  // sender bookkeeping
  int          beats_sent = 0;
  int          burst_left = 0;
  bit          burst_is_open = 1'b0;
  logic [23:0] settle_set = SETTLE_RESET;

  always #5 clk = ~clk;

  fpga_spi_config_loader i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_command           (in_command),
    .in_data_byte         (in_data_byte),
    .in_miso_bit          (in_miso_bit),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_cs_active        (out_cs_active),
    .out_mosi_bit         (out_mosi_bit),
    .out_clock_pulse      (out_clock_pulse),
    .out_engine_busy      (out_engine_busy),
    .out_response_valid   (out_response_valid),
    .out_response_word    (out_response_word),
    .out_command_rejected (out_command_rejected)
  );

  // watches both channels, predicts every result beat and compares
  fpga_spi_config_loader_check i_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_command           (in_command),
    .in_data_byte         (in_data_byte),
    .in_miso_bit          (in_miso_bit),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_cs_active        (out_cs_active),
    .out_mosi_bit         (out_mosi_bit),
    .out_clock_pulse      (out_clock_pulse),
    .out_engine_busy      (out_engine_busy),
    .out_response_valid   (out_response_valid),
    .out_response_word    (out_response_word),
    .out_command_rejected (out_command_rejected),
    .mismatches           (mismatches),
    .beats_due            (beats_due)
  );

  // offer one beat and hold it until the block takes it; entered and left at a
  // falling edge, with valid still high so the next beat can follow back to back
  task automatic send_beat(input logic [2:0] cmd, input logic [7:0] data, input logic miso);
    int gap;
    if (burst_left == 0) begin
      // new burst: a random gap first, none at all a quarter of the time
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_data_byte <= data;
    in_miso_bit  <= miso;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
    beats_sent++;
  endtask

  // one tick; while the engine is mid-sequence a stray host command may slip in
  // first, which must be rejected (or ignored for the unused codes); while idle an unused code may slip in
  task automatic send_tick_bit(input logic miso, input bit busy);
    if (busy && $urandom_range(0, 19) == 0)
      send_beat(3'($urandom_range(int'(CMD_START), int'(CMD_SPARE))),
                8'($urandom), 1'($urandom));
    else if (!busy && $urandom_range(0, 9) == 0)
      send_beat($urandom_range(0, 1) ? CMD_SPARE : CMD_NONE, 8'($urandom), 1'($urandom));
    send_beat(CMD_TICK, 8'($urandom), miso);
  endtask

  task automatic send_ticks(input int n, input bit busy);
    repeat (n) send_tick_bit(1'($urandom), busy);
  endtask

  // eight read ticks carrying one byte msb first
  task automatic send_read_byte(input logic [7:0] b);
    for (int i = 7; i >= 0; i--) send_tick_bit(b[i], 1'b1);
  endtask

  // busy poll: a non-zero answer may send it round again, then zero lets it on
  task automatic busy_poll();
    int tries;
    tries = $urandom_range(0, 1);
    repeat (tries) begin
      send_ticks(OP_TICKS, 1'b1);
      send_read_byte(8'($urandom_range(1, 255)));
    end
    send_ticks(OP_TICKS, 1'b1);
    send_read_byte(8'h00);
  endtask

  // whole start sequence, ending with the burst open
  task automatic run_start();
    send_beat(CMD_START, 8'($urandom), 1'($urandom));
    burst_is_open = 1'b0;
    send_ticks(OP_TICKS, 1'b1);                // refresh
    busy_poll();
    send_ticks(int'(settle_set), 1'b1);        // settle wait, nothing when zero
    send_ticks(2 * OP_TICKS, 1'b1);            // enable, erase
    busy_poll();
    send_ticks(OP_TICKS, 1'b1);                // set address
    send_ticks(OP_TICKS + WORD_TICKS, 1'b1);   // status read, reported
    send_ticks(OP_TICKS, 1'b1);                // burst opcode
    burst_is_open = 1'b1;
  endtask

  // read id or read status, random word
  task automatic run_read(input logic [2:0] cmd);
    send_beat(cmd, 8'($urandom), 1'($urandom));
    burst_is_open = 1'b0;
    send_ticks(OP_TICKS + WORD_TICKS, 1'b1);
  endtask

  // status read kept, disable sent, kept status reported on its last bit
  task automatic run_finish();
    send_beat(CMD_FINISH, 8'($urandom), 1'($urandom));
    burst_is_open = 1'b0;
    send_ticks(2 * OP_TICKS + WORD_TICKS, 1'b1);
  endtask

  // bitstream byte; dropped when no burst is open, the ticks then stay idle
  task automatic run_byte(input logic [7:0] data);
    send_beat(CMD_BYTE, data, 1'($urandom));
    if (burst_is_open) send_ticks(BYTE_TICKS, 1'b1);
    else send_ticks($urandom_range(1, 3), 1'b0);
  endtask

  // sender stops until every expected beat has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (beats_due != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // register written only with the engine quiet
  task automatic write_settle(input logic [23:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
    settle_set = value;
  endtask

  initial begin : stimulus
    int mark;
    int pick;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: idle ticks with both miso levels, chip select released
    send_beat(CMD_TICK, 8'h00, 1'b0);
    send_beat(CMD_TICK, 8'hFF, 1'b1);
    // unused codes while idle
    send_beat(CMD_NONE, 8'h00, 1'b0);
    send_beat(CMD_SPARE, 8'hFF, 1'b1);
    // bitstream bytes with no burst open are dropped
    send_beat(CMD_BYTE, 8'hFF, 1'b0);
    send_beat(CMD_BYTE, 8'h00, 1'b1);
    // read id of all ones, every code but the tick offered while busy
    send_beat(CMD_READ_ID, 8'h00, 1'b0);
    for (int c = int'(CMD_START); c <= int'(CMD_SPARE); c++)
      send_beat(3'(c), 8'hA5, 1'b1);
    send_ticks(OP_TICKS, 1'b1);
    repeat (4) send_read_byte(8'hFF);
    // read status of all zeros
    send_beat(CMD_READ_STATUS, 8'h00, 1'b0);
    send_ticks(OP_TICKS, 1'b1);
    repeat (4) send_read_byte(8'h00);
    // finish with no burst open runs all the same
    run_finish();

    // one configuration pass under a short settle count, zero included
    write_settle(24'($urandom_range(0, 3)));
    run_start();
    mark = beats_sent;
    while (beats_sent - mark < PHASE_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) run_byte(8'($urandom));
      else if (pick < 57) run_read(CMD_READ_ID);
      else if (pick < 69) run_read(CMD_READ_STATUS);
      else if (pick < 80) run_finish();
      else if (pick < 92) send_ticks($urandom_range(1, 6), 1'b0);
      else if (pick < 96) send_beat($urandom_range(0, 1) ? CMD_SPARE : CMD_NONE,
                                    8'($urandom), 1'($urandom));
      else send_beat(CMD_BYTE, 8'($urandom), 1'($urandom));
    end

    wait_drained();
    repeat (5) @(negedge clk);
    if (mismatches == 0 && beats_due == 0)
      $display("** fpga_spi_config_loader: PASSED **");
    else
      $display("** fpga_spi_config_loader: FAILED **");
    $finish;
  end

  // receiver stall pattern: random duty in segments, every sixth a long hold-off
  // so the input side backs up and stalls
  initial begin : result_stall
    int seg;
    int len;
    int pct;
    seg = 0;
    forever begin
      if (seg % 6 == 2) begin
        len = $urandom_range(40, 120);
        repeat (len) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        len = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0:       pct = 0;
          1:       pct = 20;
          2:       pct = 50;
          default: pct = 85;
        endcase
        repeat (len) begin
          @(negedge clk);
          out_stall <= ($urandom_range(0, 99) < pct);
        end
      end
      seg++;
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("** fpga_spi_config_loader: FAILED **");
    $finish;
  end

endmodule
